### sv/dmacr_pkg.sv
// ----------------------------------------------------------------------------
// dmacr_pkg
// Shared types, address constants and codes of the DMA register front end.
// ----------------------------------------------------------------------------
package dmacr_pkg;

  localparam int NUM_CHANNELS     = 10;
  localparam int REGS_PER_CHANNEL = 7;
  localparam int CHAN_REG_DEPTH   = NUM_CHANNELS * REGS_PER_CHANNEL;
  localparam int MEM_AW           = $clog2(CHAN_REG_DEPTH);
  localparam int MISC_DEPTH       = 5;

  localparam logic [31:0] ENABLE_RESET  = 32'h0000_1201;
  localparam logic [31:0] STATUS_ADDR   = 32'h1000_E010;
  localparam logic [31:0] ENABLE_ADDR_R = 32'h1000_F520;
  localparam logic [31:0] ENABLE_ADDR_W = 32'h1000_F590;
  localparam logic [19:0] CHAN_PAGE_LO  = 20'h10008;
  localparam logic [19:0] CHAN_PAGE_HI  = 20'h1000D;
  localparam logic [19:0] CTRL_PAGE     = 20'h1000E;
  localparam int          START_BIT     = 8;
  localparam int          MASK_LSB      = 16;

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_DONE   = 2'd2,
    OP_IRQ_EN = 2'd3
  } op_t;

  // what a bus address resolves to
  typedef enum logic [2:0] {
    DK_NONE,
    DK_CLAIM_ONLY,
    DK_CHAN,
    DK_CTRL,
    DK_STATUS_WR,
    DK_ENABLE
  } kind_t;

  // control block word select
  localparam logic [2:0] SEL_CTRL   = 3'd0;
  localparam logic [2:0] SEL_STATUS = 3'd1;
  localparam logic [2:0] SEL_MISC0  = 3'd2;
  localparam logic [2:0] SEL_MISC1  = 3'd3;
  localparam logic [2:0] SEL_MISC2  = 3'd4;
  localparam logic [2:0] SEL_MISC3  = 3'd5;
  localparam logic [2:0] SEL_MISC4  = 3'd6;
  localparam logic [2:0] SEL_ENABLE = 3'd7;

  typedef struct packed {
    kind_t             kind;
    logic [MEM_AW-1:0] mem_idx;
    logic [2:0]        sel;
    logic [3:0]        chan;
    logic              slot0;
  } decode_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

### sv/dmacr_decode.sv
// ----------------------------------------------------------------------------
// dmacr_decode
// Address decoder: channel block, register slot, control word, status write or enable word.
// ----------------------------------------------------------------------------
module dmacr_decode (
  input  logic [1:0]       op,
  input  logic [31:0]      bus_address,
  output dmacr_pkg::decode_t dec
);
  import dmacr_pkg::*;

  logic [19:0] page;
  logic [21:0] kpage;
  logic        hit;
  logic        big;
  logic [3:0]  chan;
  logic [11:0] off;
  logic [2:0]  slot;
  logic        slot_ok;
  logic        is_bus;

  assign page   = bus_address[31:12];
  assign kpage  = bus_address[31:10];
  assign is_bus = (op_t'(op) == OP_READ) || (op_t'(op) == OP_WRITE);

  always_comb begin
    hit  = 1'b1;
    big  = 1'b0;
    chan = 4'd0;
    unique case (kpage)
      22'h40020, 22'h40021, 22'h40022, 22'h40023: begin chan = 4'd0; big = 1'b1; end
      22'h40024, 22'h40025, 22'h40026, 22'h40027: begin chan = 4'd1; big = 1'b1; end
      22'h40028, 22'h40029, 22'h4002A, 22'h4002B: begin chan = 4'd2; big = 1'b1; end
      22'h4002C: chan = 4'd3;
      22'h4002D: chan = 4'd4;
      22'h40030: chan = 4'd5;
      22'h40031: chan = 4'd6;
      22'h40032: chan = 4'd7;
      22'h40034: chan = 4'd8;
      22'h40035: chan = 4'd9;
      default:   hit = 1'b0;
    endcase
  end

  assign off = big ? bus_address[11:0] : {2'b00, bus_address[9:0]};

  always_comb begin
    slot_ok = 1'b1;
    slot    = 3'd0;
    unique case (off)
      12'h000: slot = 3'd0;
      12'h010: slot = 3'd1;
      12'h020: slot = 3'd2;
      12'h030: slot = 3'd3;
      12'h040: slot = 3'd4;
      12'h050: slot = 3'd5;
      12'h080: slot = 3'd6;
      default: slot_ok = 1'b0;
    endcase
  end

  always_comb begin
    dec.kind    = DK_NONE;
    dec.chan    = chan;
    dec.slot0   = (slot == 3'd0);
    // c*7 + s
    dec.mem_idx = MEM_AW'({3'b000, chan, 3'b000} - {6'd0, chan}) + MEM_AW'(slot);
    dec.sel     = SEL_CTRL;
    if (is_bus) begin
      priority if (page >= CHAN_PAGE_LO && page <= CHAN_PAGE_HI) begin
        dec.kind = (hit && slot_ok) ? DK_CHAN : DK_CLAIM_ONLY;
      end else if (op_t'(op) == OP_WRITE && bus_address == STATUS_ADDR) begin
        dec.kind = DK_STATUS_WR;
      end else if (page == CTRL_PAGE) begin
        dec.kind = DK_CTRL;
        unique case (bus_address[11:0])
          12'h000: dec.sel = SEL_CTRL;
          12'h010: dec.sel = SEL_STATUS;
          12'h020: dec.sel = SEL_MISC0;
          12'h030: dec.sel = SEL_MISC1;
          12'h040: dec.sel = SEL_MISC2;
          12'h050: dec.sel = SEL_MISC3;
          12'h060: dec.sel = SEL_MISC4;
          default: dec.kind = DK_CLAIM_ONLY;
        endcase
      end else if (bus_address == ENABLE_ADDR_R || bus_address == ENABLE_ADDR_W) begin
        dec.kind = DK_ENABLE;
        dec.sel  = SEL_ENABLE;
      end else begin
        dec.kind = DK_NONE;
      end
    end
  end

endmodule

### sv/dmacr_chan_mem.sv
// ----------------------------------------------------------------------------
// dmacr_chan_mem
// Channel register store with registered read; per-entry valid bits give the
// all-zero reset without a clearing pass.
// ----------------------------------------------------------------------------
module dmacr_chan_mem (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [dmacr_pkg::MEM_AW-1:0] rd_addr,
  output logic [31:0]                  rd_data,
  input  logic                         wr_en,
  input  logic [dmacr_pkg::MEM_AW-1:0] wr_addr,
  input  logic [31:0]                  wr_data
);
  import dmacr_pkg::*;

  logic [31:0]               mem [CHAN_REG_DEPTH];
  logic [CHAN_REG_DEPTH-1:0] valid;
  logic [31:0]               q;
  logic                      q_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      q_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        q_vld <= valid[rd_addr];
      end
    end
  end

  assign rd_data = q_vld ? q : 32'd0;

endmodule

### sv/dmacr_ctrl_regs.sv
// ----------------------------------------------------------------------------
// dmacr_ctrl_regs
// Control, status, misc and enable words with event updates and irq gating.
// ----------------------------------------------------------------------------
module dmacr_ctrl_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               apply,
  input  logic [1:0]         op,
  input  dmacr_pkg::kind_t   kind,
  input  logic [2:0]         sel,
  input  logic [31:0]        write_data,
  input  logic [3:0]         chan_index,
  input  logic               enable_flag,
  output logic [31:0]        rd_val,
  output logic               irq_next
);
  import dmacr_pkg::*;

  logic [31:0] ctrl_word, ctrl_word_next;
  logic [31:0] status_word, status_word_next;
  logic [31:0] enable_word, enable_word_next;
  logic [31:0] misc [MISC_DEPTH];
  logic [31:0] misc_next [MISC_DEPTH];
  logic [2:0]  misc_idx;
  logic        chan_ok;
  logic [15:0] lo_n;

  assign misc_idx = sel - SEL_MISC0;
  assign chan_ok  = (chan_index < 4'(NUM_CHANNELS));

  always_comb begin
    ctrl_word_next   = ctrl_word;
    status_word_next = status_word;
    enable_word_next = enable_word;
    misc_next        = misc;
    if (apply) begin
      unique case (op_t'(op))
        OP_READ: ;
        OP_WRITE: begin
          unique case (kind)
            DK_STATUS_WR: begin
              // low half: write 1 to clear, high half: write 1 to toggle
              status_word_next[15:0]  = status_word[15:0] & ~write_data[15:0];
              status_word_next[31:16] = status_word[31:16] ^ write_data[31:16];
            end
            DK_CTRL: begin
              priority if (sel == SEL_CTRL) ctrl_word_next = write_data;
              else if (sel >= SEL_MISC0 && sel <= SEL_MISC4) misc_next[misc_idx] = write_data;
              else ;
            end
            DK_ENABLE: enable_word_next = write_data;
            default: ;
          endcase
        end
        OP_DONE: begin
          if (chan_ok) status_word_next = status_word | (32'd1 << chan_index);
        end
        OP_IRQ_EN: begin
          if (chan_ok) begin
            if (enable_flag)
              status_word_next = status_word | (32'd1 << (5'(chan_index) + 5'(MASK_LSB)));
            else
              status_word_next = status_word & ~(32'd1 << (5'(chan_index) + 5'(MASK_LSB)));
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_word   <= '0;
      status_word <= '0;
      enable_word <= ENABLE_RESET;
      for (int i = 0; i < MISC_DEPTH; i++) misc[i] <= '0;
    end else begin
      ctrl_word   <= ctrl_word_next;
      status_word <= status_word_next;
      enable_word <= enable_word_next;
      misc        <= misc_next;
    end
  end

  always_comb begin
    priority if (sel == SEL_CTRL) rd_val = ctrl_word;
    else if (sel == SEL_STATUS) rd_val = status_word;
    else if (sel == SEL_ENABLE) rd_val = enable_word;
    else if (sel >= SEL_MISC0 && sel <= SEL_MISC4) rd_val = misc[misc_idx];
    else rd_val = 32'd0;
  end

  assign lo_n     = status_word_next[15:0];
  assign irq_next = ctrl_word_next[0] && (enable_word_next[23:16] != 8'd1) &&
                    (((lo_n & status_word_next[31:16]) != 16'd0) || lo_n[15]);

endmodule

### sv/dmac_register_file_irq.sv
// ----------------------------------------------------------------------------
// dmac_register_file_irq
// Register front end of a ten-channel DMA controller: address decode, channel
// register memory, control/status words and the interrupt output.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | op, bus_address, write_data, chan_index, enable_flag
//  out     | out_valid / out_ready| read_data, claimed, kick_request, kick_channel, irq_pending
//
// Each accepted item has its address decoded and its channel memory read into
// registers; in the execute state it writes back and loads the result register.
// A new item is accepted only after the last one has left the execute state.
// Reset (rst, synchronous) resets the state, out_valid and the control/status words and
// holds in_ready low; channel valid bits give zero.
// A held result stalls the execute step; in_ready drops until it completes.
// ----------------------------------------------------------------------------
module dmac_register_file_irq (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [31:0] bus_address,
  input  logic [31:0] write_data,
  input  logic [3:0]  chan_index,
  input  logic        enable_flag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_data,
  output logic        claimed,
  output logic        kick_request,
  output logic [3:0]  kick_channel,
  output logic        irq_pending
);
  import dmacr_pkg::*;

  state_t      state, state_next;
  decode_t     dec_in, dec;
  logic [1:0]  op_q;
  logic [31:0] data_q;
  logic [3:0]  chan_q;
  logic        en_q;
  logic        accept;
  logic        done;
  logic        is_wr;
  logic [31:0] mem_rd;
  logic [31:0] ctrl_rd;
  logic        irq_next;
  logic [31:0] rd_result;

  dmacr_decode u_decode (
    .op          (op),
    .bus_address (bus_address),
    .dec         (dec_in)
  );

  assign accept = in_valid && in_ready;
  assign is_wr  = (op_t'(op_q) == OP_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    done       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        done = !out_valid || out_ready;
        if (done) state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dec    <= dec_in;
      op_q   <= op;
      data_q <= write_data;
      chan_q <= chan_index;
      en_q   <= enable_flag;
    end
  end

  dmacr_chan_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (dec_in.mem_idx),
    .rd_data (mem_rd),
    .wr_en   (done && is_wr && dec.kind == DK_CHAN),
    .wr_addr (dec.mem_idx),
    .wr_data (data_q)
  );

  dmacr_ctrl_regs u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .apply       (done),
    .op          (op_q),
    .kind        (dec.kind),
    .sel         (dec.sel),
    .write_data  (data_q),
    .chan_index  (chan_q),
    .enable_flag (en_q),
    .rd_val      (ctrl_rd),
    .irq_next    (irq_next)
  );

  always_comb begin
    rd_result = 32'd0;
    if (!is_wr) begin
      unique case (dec.kind)
        DK_CHAN:              rd_result = mem_rd;
        DK_CTRL, DK_ENABLE:   rd_result = ctrl_rd;
        default:              rd_result = 32'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      read_data    <= rd_result;
      claimed      <= (dec.kind != DK_NONE);
      kick_request <= is_wr && dec.kind == DK_CHAN && dec.slot0 && data_q[START_BIT];
      kick_channel <= (is_wr && dec.kind == DK_CHAN && dec.slot0 && data_q[START_BIT]) ?
                      dec.chan : 4'd0;
      irq_pending  <= irq_next;
    end
  end

endmodule
